[sv/qste_pkg.sv]
// Shared constants for the smallest-three quaternion encoder.
package qste_pkg;

	localparam int COMP_WIDTH      = 32;
	localparam int MAX_CODE_BITS   = 30;
	localparam int CFG_W           = 5;
	localparam int CODE_BITS_RESET = 16;
	localparam int IDX_W           = 2;
	localparam int NUM_COMP        = 4;
	localparam int NUM_KEPT        = 3;
	// Normalized magnitudes have their leading one at this bit.
	localparam int NORM_TOP        = 29;
	localparam int NORM_W          = NORM_TOP + 1;

	localparam logic [IDX_W-1:0] IDX_W_COMP = 2'd3;

endpackage

[sv/qste_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
module qste_isqrt #(
	parameter int SW = 62,
	parameter int PW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [SW-1:0]     in_s,
	input  logic [PW-1:0]     in_pay,
	output logic              out_vld,
	output logic [SW/2-1:0]   out_r,
	output logic [PW-1:0]     out_pay
);

	localparam int K = SW / 2;

	logic [SW-1:0] s_st   [0:K];
	logic [SW:0]   r_st   [0:K];
	logic [PW-1:0] pay_st [0:K];
	logic          vld_st [0:K];

	assign s_st[0]   = in_s;
	assign r_st[0]   = '0;
	assign pay_st[0] = in_pay;
	assign vld_st[0] = in_vld;

	for (genvar k = 0; k < K; k++) begin : g_stage
		localparam int SH = 2 * (K - 1 - k);
		logic [SW:0]   bit_v;
		logic [SW:0]   sum;
		logic [SW-1:0] s_nxt;
		logic [SW:0]   r_nxt;

		always_comb begin
			bit_v = (SW+1)'(1) << SH;
			sum   = r_st[k] + bit_v;
			if ({1'b0, s_st[k]} >= sum) begin
				s_nxt = s_st[k] - sum[SW-1:0];
				r_nxt = (r_st[k] >> 1) + bit_v;
			end else begin
				s_nxt = s_st[k];
				r_nxt = r_st[k] >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_st[k+1] <= 1'b0;
			end else if (en) begin
				vld_st[k+1] <= vld_st[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				s_st[k+1]   <= s_nxt;
				r_st[k+1]   <= r_nxt;
				pay_st[k+1] <= pay_st[k];
			end
		end
	end

	assign out_vld = vld_st[K];
	assign out_r   = r_st[K][SW/2-1:0];
	assign out_pay = pay_st[K];

endmodule

[sv/qste_div.sv]
// Pipelined restoring divider, several numerators over one divisor, one quotient bit per stage.
module qste_div #(
	parameter int NW = 63,
	parameter int DW = 32,
	parameter int QB = 31,
	parameter int LN = 3,
	parameter int PW = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_vld,
	input  logic [LN-1:0][NW-1:0]  in_num,
	input  logic [DW-1:0]          in_den,
	input  logic [PW-1:0]          in_pay,
	output logic                   out_vld,
	output logic [LN-1:0][QB-1:0]  out_q,
	output logic [PW-1:0]          out_pay
);

	localparam int XW = NW + DW;

	logic [LN-1:0][NW-1:0] rem_st [0:QB];
	logic [LN-1:0][QB-1:0] q_st   [0:QB];
	logic [DW-1:0]         den_st [0:QB];
	logic [PW-1:0]         pay_st [0:QB];
	logic                  vld_st [0:QB];

	assign rem_st[0] = in_num;
	assign q_st[0]   = '0;
	assign den_st[0] = in_den;
	assign pay_st[0] = in_pay;
	assign vld_st[0] = in_vld;

	for (genvar k = 0; k < QB; k++) begin : g_stage
		localparam int SH = QB - 1 - k;
		logic [LN-1:0][NW-1:0] rem_nxt;
		logic [LN-1:0][QB-1:0] q_nxt;
		logic [XW-1:0]         dsh;

		always_comb begin
			dsh = {{NW{1'b0}}, den_st[k]} << SH;
			for (int j = 0; j < LN; j++) begin
				if ({{DW{1'b0}}, rem_st[k][j]} >= dsh) begin
					rem_nxt[j] = rem_st[k][j] - dsh[NW-1:0];
					q_nxt[j]   = {q_st[k][j][QB-2:0], 1'b1};
				end else begin
					rem_nxt[j] = rem_st[k][j];
					q_nxt[j]   = {q_st[k][j][QB-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_st[k+1] <= 1'b0;
			end else if (en) begin
				vld_st[k+1] <= vld_st[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_st[k+1] <= rem_nxt;
				q_st[k+1]   <= q_nxt;
				den_st[k+1] <= den_st[k];
				pay_st[k+1] <= pay_st[k];
			end
		end
	end

	assign out_vld = vld_st[QB];
	assign out_q   = q_st[QB];
	assign out_pay = pay_st[QB];

endmodule

[sv/quat_smallest_three_encode_top.sv]
// Top level of the smallest-three quaternion encoder.
//
//   Channel  Direction  Payload (lowest bit first)
//   s_*      in         comp_x, comp_y, comp_z, comp_w
//   m_*      out        largest_index, code_first, code_second, code_third
//   cfg_*    in         code_bits
//
// One quaternion enters per cycle while the output is not stalled. The pipeline has four
// front stages, NORM_W+1 square-root stages, two code setup stages and MAX_CODE_BITS+1
// divider stages. The square root and the code divider set the depth.
// Reset clears every valid bit and loads code_bits with 16.
// A stall on the output freezes the whole pipeline, and s_tready drops with it.
module quat_smallest_three_encode_top #(
	parameter int COMPONENT_WIDTH = qste_pkg::COMP_WIDTH,
	parameter int MAX_CODE_BITS   = qste_pkg::MAX_CODE_BITS
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// comp_x, comp_y, comp_z, comp_w
	input  logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0]    s_tdata,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// largest_index, code_first, code_second, code_third
	output logic [((2+3*MAX_CODE_BITS+7)/8)*8-1:0]    m_tdata,
	input  logic                                      cfg_wen,
	input  logic [qste_pkg::CFG_W-1:0]                cfg_wdata
);

	localparam int CW   = COMPONENT_WIDTH;
	localparam int MB   = MAX_CODE_BITS;
	localparam int NW   = qste_pkg::NORM_W;
	localparam int NT   = qste_pkg::NORM_TOP;
	localparam int IW   = qste_pkg::IDX_W;
	localparam int NC   = qste_pkg::NUM_COMP;
	localparam int NK   = qste_pkg::NUM_KEPT;
	localparam int SW   = 2 * NW + 2;
	localparam int RW   = SW / 2;
	localparam int TW   = RW + 1;
	localparam int NUMW = TW + MB + 1;
	localparam int QB   = MB + 1;
	localparam int PW   = $clog2(CW);
	localparam int IPW  = IW + NC + NC * NW;
	localparam int DPW  = IW + MB;
	localparam int ODW  = ((2 + 3 * MB + 7) / 8) * 8;

	logic en;
	logic [qste_pkg::CFG_W-1:0] code_bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_bits_q <= qste_pkg::CFG_W'(qste_pkg::CODE_BITS_RESET);
		end else if (cfg_wen) begin
			code_bits_q <= cfg_wdata;
		end
	end

	// Stage 1: sign fold, largest pick, magnitudes.
	logic signed [CW:0] v [NC];
	logic [IW-1:0]      idx_c;
	logic               vld_s1;
	logic [IW-1:0]      idx_s1;
	logic [NC-1:0]      neg_s1;
	logic [NC-1:0][CW-1:0] mag_s1;
	logic [NC-1:0]      neg_c;
	logic [NC-1:0][CW-1:0] mag_c;

	always_comb begin
		for (int i = 0; i < NC; i++) begin
			v[i] = (CW+1)'(signed'(s_tdata[i*CW +: CW]));
		end
		if (v[0] == 0 && v[1] == 0 && v[2] == 0 && v[3] == 0) begin
			v[3] = (CW+1)'(1);
		end
		if (v[3] < 0) begin
			for (int i = 0; i < NC; i++) begin
				v[i] = -v[i];
			end
		end
		idx_c = '0;
		for (int i = 1; i < NC; i++) begin
			if (v[i] > v[idx_c]) begin
				idx_c = IW'(i);
			end
		end
		for (int i = 0; i < NC; i++) begin
			neg_c[i] = v[i] < 0;
			mag_c[i] = neg_c[i] ? CW'(-v[i]) : CW'(v[i]);
		end
	end

	// Stage 2: common shift that puts the largest leading one at the top.
	logic [CW-1:0]          ormag;
	logic [PW-1:0]          lead;
	logic [NC-1:0][NW-1:0]  nm_c;
	logic [CW+NW-1:0]       wide;
	logic                   vld_s2;
	logic [IW-1:0]          idx_s2;
	logic [NC-1:0]          neg_s2;
	logic [NC-1:0][NW-1:0]  nm_s2;

	always_comb begin
		ormag = '0;
		for (int i = 0; i < NC; i++) begin
			ormag = ormag | mag_s1[i];
		end
		lead = '0;
		for (int i = 0; i < CW; i++) begin
			if (ormag[i]) begin
				lead = PW'(i);
			end
		end
		for (int i = 0; i < NC; i++) begin
			wide = {{NW{1'b0}}, mag_s1[i]};
			if (int'(lead) >= NT) begin
				wide = wide >> (int'(lead) - NT);
			end else begin
				wide = wide << (NT - int'(lead));
			end
			nm_c[i] = wide[NW-1:0];
		end
	end

	// Stage 3: squares. Stage 4: their sum.
	logic                    vld_s3;
	logic [IW-1:0]           idx_s3;
	logic [NC-1:0]           neg_s3;
	logic [NC-1:0][NW-1:0]   nm_s3;
	logic [NC-1:0][2*NW-1:0] sq_s3;
	logic                    vld_s4;
	logic [IW-1:0]           idx_s4;
	logic [NC-1:0]           neg_s4;
	logic [NC-1:0][NW-1:0]   nm_s4;
	logic [SW-1:0]           sum_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1 <= idx_c;
			neg_s1 <= neg_c;
			mag_s1 <= mag_c;
			idx_s2 <= idx_s1;
			neg_s2 <= neg_s1;
			nm_s2  <= nm_c;
			idx_s3 <= idx_s2;
			neg_s3 <= neg_s2;
			nm_s3  <= nm_s2;
			for (int i = 0; i < NC; i++) begin
				sq_s3[i] <= nm_s2[i] * nm_s2[i];
			end
			idx_s4 <= idx_s3;
			neg_s4 <= neg_s3;
			nm_s4  <= nm_s3;
			sum_s4 <= SW'(sq_s3[0]) + SW'(sq_s3[1]) + SW'(sq_s3[2]) + SW'(sq_s3[3]);
		end
	end

	logic            sq_vld;
	logic [RW-1:0]   sq_r;
	logic [IPW-1:0]  sq_pay;

	qste_isqrt #(.SW(SW), .PW(IPW)) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s4),
		.in_s    (sum_s4),
		.in_pay  ({idx_s4, neg_s4, nm_s4}),
		.out_vld (sq_vld),
		.out_r   (sq_r),
		.out_pay (sq_pay)
	);

	// Stage 5: pick the kept lanes and offset them by the root.
	logic [IW-1:0]          p_idx;
	logic [NC-1:0]          p_neg;
	logic [NC-1:0][NW-1:0]  p_nm;
	logic [RW-1:0]          r_c;
	logic [qste_pkg::CFG_W-1:0] bits_c;
	logic [MB:0]            lev_w;
	logic [NK-1:0][TW-1:0]  t_c;
	logic                   vld_s5;
	logic [IW-1:0]          idx_s5;
	logic [RW-1:0]          r_s5;
	logic [MB-1:0]          lev_s5;
	logic [NK-1:0][TW-1:0]  t_s5;

	assign {p_idx, p_neg, p_nm} = sq_pay;

	always_comb begin
		logic [IW-1:0] li;
		logic [RW-1:0] m;
		r_c = (sq_r == '0) ? RW'(1) : sq_r;
		bits_c = code_bits_q;
		if (bits_c < qste_pkg::CFG_W'(1)) begin
			bits_c = qste_pkg::CFG_W'(1);
		end
		if (bits_c > qste_pkg::CFG_W'(MB)) begin
			bits_c = qste_pkg::CFG_W'(MB);
		end
		lev_w = ((MB+1)'(1) << bits_c) - (MB+1)'(1);
		for (int j = 0; j < NK; j++) begin
			li = (IW'(j) < p_idx) ? IW'(j) : IW'(j + 1);
			m  = RW'(p_nm[li]);
			if (m > r_c) begin
				m = r_c;
			end
			t_c[j] = p_neg[li] ? TW'(r_c - m) : (TW'(r_c) + TW'(m));
		end
	end

	// Stage 6: numerators t * L + r, divisor 2r.
	logic                   vld_s6;
	logic [IW-1:0]          idx_s6;
	logic [MB-1:0]          lev_s6;
	logic [TW-1:0]          den_s6;
	logic [NK-1:0][NUMW-1:0] num_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s5 <= sq_vld;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s5 <= p_idx;
			r_s5   <= r_c;
			lev_s5 <= lev_w[MB-1:0];
			t_s5   <= t_c;
			idx_s6 <= idx_s5;
			lev_s6 <= lev_s5;
			den_s6 <= {r_s5, 1'b0};
			for (int j = 0; j < NK; j++) begin
				num_s6[j] <= NUMW'(t_s5[j]) * NUMW'(lev_s5) + NUMW'(r_s5);
			end
		end
	end

	logic                    dv_vld;
	logic [NK-1:0][QB-1:0]   dv_q;
	logic [DPW-1:0]          dv_pay;
	logic [IW-1:0]           o_idx;
	logic [MB-1:0]           o_lev;
	logic [NK-1:0][MB-1:0]   code;

	qste_div #(.NW(NUMW), .DW(TW), .QB(QB), .LN(NK), .PW(DPW)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s6),
		.in_num  (num_s6),
		.in_den  (den_s6),
		.in_pay  ({idx_s6, lev_s6}),
		.out_vld (dv_vld),
		.out_q   (dv_q),
		.out_pay (dv_pay)
	);

	assign {o_idx, o_lev} = dv_pay;

	always_comb begin
		for (int j = 0; j < NK; j++) begin
			code[j] = (dv_q[j] > {1'b0, o_lev}) ? o_lev : dv_q[j][MB-1:0];
		end
	end

	assign en       = !dv_vld || m_tready;
	assign s_tready = en;
	assign m_tvalid = dv_vld;
	assign m_tdata  = ODW'({code[2], code[1], code[0], o_idx});

endmodule

[sv/qste_chk.sv]
// Port-level checker for the smallest-three encoder, bound to the top level.
module qste_chk #(
	parameter int ODW = 96
) (
	input logic           clk,
	input logic           arst_n,
	input logic           s_tvalid,
	input logic           s_tready,
	input logic           m_tvalid,
	input logic           m_tready,
	input logic [ODW-1:0] m_tdata
);

	// A held result stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// With the output empty or draining, the input side must be open.
	a_open_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

	a_open_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input blocked while output drains");

endmodule

bind quat_smallest_three_encode_top qste_chk #(.ODW(ODW)) u_qste_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[tb/sv/tb_quat_smallest_three_encode_top.sv]
// Testbench for the smallest-three quaternion encoder: directed and random quaternions checked against a local predictor.
module tb_quat_smallest_three_encode_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW = ((4*qste_pkg::COMP_WIDTH+7)/8)*8;
	localparam int MW = ((2+3*qste_pkg::MAX_CODE_BITS+7)/8)*8;
	localparam int LATENCY = 80;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [29:0] code_c;
		logic [29:0] code_b;
		logic [29:0] code_a;
		logic [qste_pkg::IDX_W-1:0] largest;
	} code_set_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [SW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [MW-1:0] m_tdata;
	logic cfg_wen = 1'b0;
	logic [qste_pkg::CFG_W-1:0] cfg_wdata = '0;

	quat_smallest_three_encode_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	code_set_t expected_codes[$];
	logic [qste_pkg::CFG_W-1:0] code_bits_reg = qste_pkg::CODE_BITS_RESET;
	int error_count = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off_cycles = 0;

	function automatic longint unsigned int_sqrt(longint unsigned s);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > s)
			bitv >>= 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic code_set_t encode_quat(
			logic signed [qste_pkg::COMP_WIDTH-1:0] comp[4],
			logic [qste_pkg::CFG_W-1:0] cfg);
		code_set_t cs;
		longint signed v[4];
		longint unsigned mag[4];
		bit neg[4];
		longint unsigned m, s, r, levels, t, code;
		int largest, nbits, slot;
		cs = '0;
		m = 0;
		s = 0;
		for (int i = 0; i < 4; i++)
			v[i] = comp[i];
		if (v[0] == 0 && v[1] == 0 && v[2] == 0 && v[3] == 0)
			v[3] = 1;
		if (v[3] < 0)
			for (int i = 0; i < 4; i++)
				v[i] = -v[i];
		largest = 0;
		for (int i = 1; i < 4; i++)
			if (v[i] > v[largest])
				largest = i;
		for (int i = 0; i < 4; i++) begin
			neg[i] = v[i] < 0;
			mag[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
			if (mag[i] > m)
				m = mag[i];
		end
		// Bring the largest magnitude into [2^29, 2^30).
		while ((m >> 30) != 0) begin
			m >>= 1;
			for (int i = 0; i < 4; i++)
				mag[i] >>= 1;
		end
		while (m < (64'd1 << qste_pkg::NORM_TOP)) begin
			m <<= 1;
			for (int i = 0; i < 4; i++)
				mag[i] <<= 1;
		end
		for (int i = 0; i < 4; i++)
			s += mag[i] * mag[i];
		r = int_sqrt(s);
		if (r == 0)
			r = 1;
		nbits = cfg;
		if (nbits < 1)
			nbits = 1;
		if (nbits > qste_pkg::MAX_CODE_BITS)
			nbits = qste_pkg::MAX_CODE_BITS;
		levels = (64'd1 << nbits) - 1;
		cs.largest = largest[qste_pkg::IDX_W-1:0];
		slot = 0;
		for (int i = 0; i < 4; i++) begin
			if (i == largest)
				continue;
			if (mag[i] > r)
				mag[i] = r;
			t = neg[i] ? r - mag[i] : r + mag[i];
			code = (t * levels + r) / (2 * r);
			if (code > levels)
				code = levels;
			if (slot == 0)
				cs.code_a = code[29:0];
			else if (slot == 1)
				cs.code_b = code[29:0];
			else
				cs.code_c = code[29:0];
			slot++;
		end
		return cs;
	endfunction

	task automatic send_quat(logic signed [qste_pkg::COMP_WIDTH-1:0] x,
			logic signed [qste_pkg::COMP_WIDTH-1:0] y,
			logic signed [qste_pkg::COMP_WIDTH-1:0] z,
			logic signed [qste_pkg::COMP_WIDTH-1:0] w);
		logic signed [qste_pkg::COMP_WIDTH-1:0] comp[4];
		comp[0] = x;
		comp[1] = y;
		comp[2] = z;
		comp[3] = w;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {w, z, y, x};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_codes = {expected_codes, encode_quat(comp, code_bits_reg)};
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	// Waits for the pipeline to drain before a register write.
	task automatic wait_drained();
		while (expected_codes.size() != 0)
			@(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	task automatic write_code_bits(logic [qste_pkg::CFG_W-1:0] val);
		wait_drained();
		cfg_wen <= 1'b1;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wen <= 1'b0;
		code_bits_reg = val;
	endtask

	function automatic logic signed [qste_pkg::COMP_WIDTH-1:0] rand_comp();
		case ($urandom_range(5))
			0: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
			1: return $signed(32'($urandom_range(16'hFFFF))) - 32'sd32768;
			2: return $signed(32'($urandom_range(3)) - 32'sd1);
			3: return 32'sh40000000 - $signed(32'($urandom_range(255)));
			default: return $signed($urandom());
		endcase
	endfunction

	task automatic test_directed();
		send_quat(0, 0, 0, 0);
		send_quat(0, 0, 0, 32'sh40000000);
		send_quat(32'sh40000000, 0, 0, 0);
		send_quat(0, 32'sh40000000, 0, 0);
		send_quat(0, 0, 32'sh40000000, 0);
		send_quat(0, 0, 0, 32'sh80000000);
		send_quat(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_quat(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		send_quat(32'sh80000000, 32'sh7FFFFFFF, 0, -1);
		send_quat(1, 1, 1, 1);
		send_quat(-1, 0, 0, 0);
		send_quat(32'sh20000000, 32'sh20000000, 32'sh20000000, 32'sh20000000);
		send_quat(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1);
		send_quat(-5, 3, -7, -2);
		send_quat(32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA, 32'h00000001);
	endtask

	task automatic test_random(int count);
		for (int n = 0; n < count; n++)
			send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
	endtask

	task automatic test_backpressure();
		hold_off_cycles = 300;
		test_random(120);
	endtask

	task automatic test_code_widths();
		logic [qste_pkg::CFG_W-1:0] widths[6] = '{5'd0, 5'd1, 5'd30, 5'd31, 5'd8, 5'd16};
		foreach (widths[k]) begin
			write_code_bits(widths[k]);
			test_directed();
			test_random(60);
		end
	endtask

	task automatic test_idling();
		int sp[4] = '{0, 85, 0, 33};
		int rp[4] = '{0, 0, 85, 33};
		for (int k = 0; k < 4; k++) begin
			send_idle_pct = sp[k];
			recv_stall_pct = rp[k];
			write_code_bits(5'($urandom_range(31)));
			test_random(k == 1 || k == 2 ? 80 : 120);
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	// Receiver: random stalls plus an optional long hold-off.
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			m_tready <= 1'b0;
			hold_off_cycles <= hold_off_cycles - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		code_set_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[2+3*qste_pkg::MAX_CODE_BITS-1:0];
			if (expected_codes.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				error_count++;
			end else begin
				want = expected_codes.pop_front();
				if (got.largest !== want.largest) begin
					$display("%0t: largest_index expected %0d actual %0d", $time,
						want.largest, got.largest);
					error_count++;
				end
				if (got.code_a !== want.code_a) begin
					$display("%0t: code_first expected %0d actual %0d", $time,
						want.code_a, got.code_a);
					error_count++;
				end
				if (got.code_b !== want.code_b) begin
					$display("%0t: code_second expected %0d actual %0d", $time,
						want.code_b, got.code_b);
					error_count++;
				end
				if (got.code_c !== want.code_c) begin
					$display("%0t: code_third expected %0d actual %0d", $time,
						want.code_c, got.code_c);
					error_count++;
				end
			end
		end
	end

	// Watchdog: counts cycles without any transfer on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(200);
		test_code_widths();
		test_idling();
		test_backpressure();
		write_code_bits(5'd12);
		test_random(200);
		wait_drained();
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
